@@ rtl/led_blink_fade_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// led blink and fade controller assertion macros
// shared property forms for the controller checks
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_FADE_CONTROLLER_CORE_MACROS_SVH
`define LED_BLINK_FADE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LBFC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbfc same-cycle check failed");

// next-cycle implication, sampled on clock, off during reset
`define LBFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbfc next-cycle check failed");

`endif

@@ rtl/lbfc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfc_pkg
// widths, defaults and codes of the led blink and fade controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbfc_pkg;

   // default widths
   localparam int DEFAULT_TIME_BITS  = 16;
   localparam int DEFAULT_LEVEL_BITS = 8;

   // fixed field widths
   localparam int MODE_BITS      = 3;
   localparam int COUNT_BITS     = 16;
   localparam int LIGHT_BITS     = 3;
   localparam int CSR_INDEX_BITS = 2;

   // reset phase length in ticks
   localparam int DEFAULT_PHASE_TICKS = 500;

   // command codes
   typedef enum logic [MODE_BITS-1:0] {
      MODE_TICK     = 3'd0,
      MODE_OFF      = 3'd1,
      MODE_ON_HIGH  = 3'd2,
      MODE_ON_LEVEL = 3'd3,
      MODE_BLINK    = 3'd4,
      MODE_FADE     = 3'd5
   } mode_type;

   // light phase codes, also reported on the result word
   typedef enum logic [LIGHT_BITS-1:0] {
      LIGHT_OFF        = 3'd0,
      LIGHT_ON         = 3'd1,
      LIGHT_BLINK_HIGH = 3'd2,
      LIGHT_BLINK_LOW  = 3'd3,
      LIGHT_RAMP_UP    = 3'd4,
      LIGHT_RAMP_DOWN  = 3'd5
   } light_type;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HIGH_LEVEL = 2'd0,
      REG_LOW_LEVEL  = 2'd1,
      REG_HIGH_TIME  = 2'd2,
      REG_LOW_TIME   = 2'd3
   } reg_index_type;

endpackage

`default_nettype wire

@@ rtl/led_blink_fade_controller_core.sv @@
// ----------------------------------------------------------------------------
// led_blink_fade_controller_core
// blink and fade pattern generator for one led, driven by commands and ticks
// ----------------------------------------------------------------------------
// Each request word is a command (off, on, on at a level, blink, fade) or a
// millisecond tick, and each produces one response word with the brightness
// and light phase after the update. Commands, and ticks that need no
// interpolation, are answered straight from idle. A tick in mid fade ramp
// steps through the sequencer states: idle takes the word and latches the
// operands, S_MUL multiplies the level span by the elapsed ticks, S_DIV runs
// a shared restoring divider that divides by the phase length one quotient
// bit per cycle, and S_FIN applies the step.
// Only one word is in flight; a new request is taken once the sequencer is
// idle and the response register is empty or being read in that cycle.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_fade_controller_core #(
   parameter int TIME_BITS  = lbfc_pkg::DEFAULT_TIME_BITS,
   parameter int LEVEL_BITS = lbfc_pkg::DEFAULT_LEVEL_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lbfc_pkg::MODE_BITS-1:0]      req_mode,
   input  wire logic [LEVEL_BITS-1:0]               req_level_in,
   input  wire logic [lbfc_pkg::COUNT_BITS-1:0]     req_repeat_count,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [LEVEL_BITS-1:0]                    rsp_level_out,
   output logic [lbfc_pkg::LIGHT_BITS-1:0]          rsp_light_state,
   // configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lbfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] csr_wdata
);

   import lbfc_pkg::*;

   localparam int PROD_BITS = LEVEL_BITS + TIME_BITS;
   localparam int CNT_BITS  = $clog2(LEVEL_BITS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FIN
   } seq_state_type;

   // sequencer and response registers
   seq_state_type             state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]     rsp_level_ff, rsp_level_in;
   logic [LIGHT_BITS-1:0]     rsp_light_ff, rsp_light_in;

   // configuration registers
   logic [LEVEL_BITS-1:0]     high_level_ff, high_level_in;
   logic [LEVEL_BITS-1:0]     low_level_ff, low_level_in;
   logic [TIME_BITS-1:0]      high_time_ff, high_time_in;
   logic [TIME_BITS-1:0]      low_time_ff, low_time_in;

   // pattern state
   light_type                 phase_ff, phase_in;
   logic [TIME_BITS-1:0]      phase_ticks_ff, phase_ticks_in;
   logic [COUNT_BITS-1:0]     cycles_left_ff, cycles_left_in;
   logic [LEVEL_BITS-1:0]     brightness_ff, brightness_in;
   logic [LEVEL_BITS-1:0]     ramp_from_ff, ramp_from_in;
   logic [LEVEL_BITS-1:0]     ramp_to_ff, ramp_to_in;

   // divider datapath
   logic [LEVEL_BITS-1:0]     div_diff_ff, div_diff_in;
   logic                      div_neg_ff, div_neg_in;
   logic [TIME_BITS-1:0]      div_len_ff, div_len_in;
   logic [TIME_BITS-1:0]      rem_ff, rem_in;
   logic [LEVEL_BITS-1:0]     quot_ff, quot_in;
   logic [CNT_BITS-1:0]       div_cnt_ff, div_cnt_in;

   // helpers
   logic                      req_fire;
   logic                      go_div;
   logic                      is_active;
   logic                      is_blink;
   logic                      is_rise;
   logic [TIME_BITS-1:0]      ticks_inc;
   logic [TIME_BITS-1:0]      cur_len;
   logic [COUNT_BITS-1:0]     cycles_dec;
   logic [PROD_BITS-1:0]      prod;
   logic [TIME_BITS:0]        trial;
   logic                      trial_ge;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level_out   = rsp_level_ff;
   assign rsp_light_state = rsp_light_ff;

   // phase classification and tick arithmetic
   assign is_blink  = (phase_ff == LIGHT_BLINK_HIGH) || (phase_ff == LIGHT_BLINK_LOW);
   assign is_active = is_blink || (phase_ff == LIGHT_RAMP_UP) ||
                      (phase_ff == LIGHT_RAMP_DOWN);
   assign is_rise   = (phase_ff == LIGHT_BLINK_HIGH) || (phase_ff == LIGHT_RAMP_UP);
   assign ticks_inc = (phase_ticks_ff == {TIME_BITS{1'b1}}) ? phase_ticks_ff
                                                            : phase_ticks_ff + 1'b1;
   assign cur_len   = is_rise ? high_time_ff : low_time_ff;

   // full cycle count, endless when the sign bit is set
   assign cycles_dec = ((cycles_left_ff != '0) && !cycles_left_ff[COUNT_BITS-1])
                       ? cycles_left_ff - 1'b1 : cycles_left_ff;

   // shared multiplier and divider step
   assign prod     = PROD_BITS'(div_diff_ff) * PROD_BITS'(phase_ticks_ff);
   assign trial    = {rem_ff, quot_ff[LEVEL_BITS-1]};
   assign trial_ge = trial >= {1'b0, div_len_ff};

   // next-state logic
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_level_in   = rsp_level_ff;
      rsp_light_in   = rsp_light_ff;
      high_level_in  = high_level_ff;
      low_level_in   = low_level_ff;
      high_time_in   = high_time_ff;
      low_time_in    = low_time_ff;
      phase_in       = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      cycles_left_in = cycles_left_ff;
      brightness_in  = brightness_ff;
      ramp_from_in   = ramp_from_ff;
      ramp_to_in     = ramp_to_ff;
      div_diff_in    = div_diff_ff;
      div_neg_in     = div_neg_ff;
      div_len_in     = div_len_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      div_cnt_in     = div_cnt_ff;
      go_div         = 1'b0;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HIGH_LEVEL: high_level_in = csr_wdata[LEVEL_BITS-1:0];
            REG_LOW_LEVEL:  low_level_in  = csr_wdata[LEVEL_BITS-1:0];
            REG_HIGH_TIME:  high_time_in  = csr_wdata[TIME_BITS-1:0];
            REG_LOW_TIME:   low_time_in   = csr_wdata[TIME_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_TICK: begin
                     if (is_active) begin
                        if (cycles_left_ff == '0) begin
                           // count used up: go dark at the low level
                           brightness_in = low_level_ff;
                           phase_in      = LIGHT_OFF;
                        end else if (is_blink) begin
                           if (ticks_inc < cur_len) begin
                              phase_ticks_in = ticks_inc;
                           end else begin
                              phase_ticks_in = '0;
                              if (phase_ff == LIGHT_BLINK_LOW) begin
                                 brightness_in  = high_level_ff;
                                 phase_in       = LIGHT_BLINK_HIGH;
                                 cycles_left_in = cycles_dec;
                              end else begin
                                 brightness_in = low_level_ff;
                                 phase_in      = LIGHT_BLINK_LOW;
                              end
                           end
                        end else if (ticks_inc < cur_len) begin
                           // mid-ramp: interpolate on the divider
                           phase_ticks_in = ticks_inc;
                           go_div         = 1'b1;
                           div_len_in     = cur_len;
                           div_neg_in     = ramp_to_ff < ramp_from_ff;
                           div_diff_in    = (ramp_to_ff < ramp_from_ff)
                                            ? ramp_from_ff - ramp_to_ff
                                            : ramp_to_ff - ramp_from_ff;
                        end else begin
                           // ramp end: turn around from the target
                           brightness_in  = ramp_to_ff;
                           ramp_from_in   = ramp_to_ff;
                           phase_ticks_in = '0;
                           if (phase_ff == LIGHT_RAMP_DOWN) begin
                              phase_in       = LIGHT_RAMP_UP;
                              ramp_to_in     = high_level_ff;
                              cycles_left_in = cycles_dec;
                           end else begin
                              phase_in   = LIGHT_RAMP_DOWN;
                              ramp_to_in = low_level_ff;
                           end
                        end
                     end
                  end
                  MODE_OFF: begin
                     brightness_in = '0;
                     phase_in      = LIGHT_OFF;
                  end
                  MODE_ON_HIGH: begin
                     brightness_in = high_level_ff;
                     phase_in      = LIGHT_ON;
                  end
                  MODE_ON_LEVEL: begin
                     brightness_in = req_level_in;
                     phase_in      = LIGHT_ON;
                  end
                  MODE_BLINK: begin
                     cycles_left_in = req_repeat_count;
                     phase_ticks_in = '0;
                     if (req_repeat_count == '0) begin
                        brightness_in = low_level_ff;
                        phase_in      = LIGHT_OFF;
                     end else begin
                        brightness_in = high_level_ff;
                        phase_in      = LIGHT_BLINK_HIGH;
                     end
                  end
                  MODE_FADE: begin
                     cycles_left_in = req_repeat_count;
                     brightness_in  = low_level_ff;
                     ramp_from_in   = low_level_ff;
                     ramp_to_in     = high_level_ff;
                     phase_ticks_in = '0;
                     phase_in       = LIGHT_RAMP_UP;
                  end
                  default: ;
               endcase

               if (go_div) begin
                  state_in = S_MUL;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = brightness_in;
                  rsp_light_in = phase_in;
               end
            end
         end
         S_MUL: begin
            // product split into partial remainder and dividend bits
            rem_in     = prod[PROD_BITS-1:LEVEL_BITS];
            quot_in    = prod[LEVEL_BITS-1:0];
            div_cnt_in = CNT_BITS'(LEVEL_BITS);
            state_in   = S_DIV;
         end
         S_DIV: begin
            // one restoring step per cycle
            if (trial_ge) begin
               rem_in = TIME_BITS'(trial - {1'b0, div_len_ff});
            end else begin
               rem_in = trial[TIME_BITS-1:0];
            end
            quot_in    = (quot_ff << 1) | LEVEL_BITS'(trial_ge);
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == CNT_BITS'(1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // step toward the target by the truncated quotient
            brightness_in = div_neg_ff ? ramp_from_ff - quot_ff : ramp_from_ff + quot_ff;
            rsp_valid_in  = 1'b1;
            rsp_level_in  = brightness_in;
            rsp_light_in  = phase_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         high_level_ff  <= '1;
         low_level_ff   <= '0;
         high_time_ff   <= TIME_BITS'(DEFAULT_PHASE_TICKS);
         low_time_ff    <= TIME_BITS'(DEFAULT_PHASE_TICKS);
         phase_ff       <= LIGHT_OFF;
         phase_ticks_ff <= '0;
         cycles_left_ff <= '0;
         brightness_ff  <= '0;
         ramp_from_ff   <= '0;
         ramp_to_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         high_level_ff  <= high_level_in;
         low_level_ff   <= low_level_in;
         high_time_ff   <= high_time_in;
         low_time_ff    <= low_time_in;
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         cycles_left_ff <= cycles_left_in;
         brightness_ff  <= brightness_in;
         ramp_from_ff   <= ramp_from_in;
         ramp_to_ff     <= ramp_to_in;
      end
      rsp_level_ff <= rsp_level_in;
      rsp_light_ff <= rsp_light_in;
      div_diff_ff  <= div_diff_in;
      div_neg_ff   <= div_neg_in;
      div_len_ff   <= div_len_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      div_cnt_ff   <= div_cnt_in;
   end

   // checks
   `include "led_blink_fade_controller_core_macros.svh"

   `LBFC_ASSERT_SAME(a_busy_not_ready, state_ff != S_IDLE, !req_ready)
   `LBFC_ASSERT_SAME(a_rem_below_len, state_ff == S_DIV, rem_ff < div_len_ff)
   `LBFC_ASSERT_NEXT(a_ramp_tick_divides, req_fire && go_div, state_ff == S_MUL)
   `LBFC_ASSERT_NEXT(a_fin_gives_word, state_ff == S_FIN, rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire
